// ----- rtl/motor_cascade_controller_top_assert.svh -----
// Assertion macros for the motor cascade controller RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef MOTOR_CASCADE_CONTROLLER_TOP_ASSERT_SVH
`define MOTOR_CASCADE_CONTROLLER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MCC_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcc: same-cycle check failed");
`define MCC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcc: next-cycle check failed");
`else
`define MCC_ASSERT_IMPL(name, clk, rst, ante, cons)
`define MCC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/mcc_pkg.sv -----
// Shared types, constants and helpers for the motor cascade controller.
// No dependencies.
package mcc_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int PERIOD_SHIFT = 14;
   localparam int DATA_W       = 32;
   localparam int CFG_W        = 31;
   localparam int CSR_IDX_W    = 3;
   localparam int WIDE_W       = 58;

   localparam logic signed [DATA_W-1:0] FILTER_KP = 32'sd1034878976;
   localparam logic signed [DATA_W-1:0] FILTER_KI = 32'sd16449536;
   localparam longint DECAY_L = ((longint'(99) << FRAC_BITS) + 50) / 100;
   localparam logic signed [DATA_W-1:0] DECAY_Q = DATA_W'(DECAY_L);

   localparam int ANGLE_SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
   localparam int ANGLE_SHR = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam wide_type ONE_TURN  = wide_type'(64'sd1 <<< FRAC_BITS);
   localparam wide_type HALF_TURN = wide_type'(64'sd1 <<< (FRAC_BITS - 1));

   typedef enum logic [1:0] {
      MODE_CURRENT  = 2'd0,
      MODE_VELOCITY = 2'd1,
      MODE_POSITION = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE      = 3'd0,
      CSR_RAMP_STEP = 3'd1,
      CSR_FF_GAIN   = 3'd2,
      CSR_POS_GAIN  = 3'd3,
      CSR_VEL_GAIN  = 3'd4,
      CSR_INT_GAIN  = 3'd5,
      CSR_VEL_LIMIT = 3'd6,
      CSR_CUR_LIMIT = 3'd7
   } csr_idx_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SETPT, S_HOLD, S_FF, S_F1, S_F2, S_F3, S_F4,
      S_VLIM, S_PI, S_IMAX, S_IMIN, S_CLIM, S_INT, S_DONE
   } state_type;

   typedef struct packed {
      logic                     restart;
      logic                     running;
      logic signed [DATA_W-1:0] target;
      logic signed [DATA_W-1:0] measured_position;
      logic signed [DATA_W-1:0] measured_velocity;
      logic [15:0]              angle_in_turn;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] current_command;
      logic                     saturated;
   } rsp_type;

   typedef struct packed {
      logic                     start;
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
   } mul_req_type;

   function automatic wide_type ext32(logic signed [DATA_W-1:0] x);
      return {{(WIDE_W-DATA_W){x[DATA_W-1]}}, x};
   endfunction

   function automatic wide_type pos31(logic [CFG_W-1:0] x);
      return {{(WIDE_W-CFG_W){1'b0}}, x};
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(wide_type x);
      if ((&x[WIDE_W-1:DATA_W-1]) || !(|x[WIDE_W-1:DATA_W-1])) begin
         return x[DATA_W-1:0];
      end
      return x[WIDE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
   endfunction

   function automatic wide_type clamp_sym(wide_type x, logic [CFG_W-1:0] lim);
      if (x > pos31(lim)) begin
         return pos31(lim);
      end
      if (x < -pos31(lim)) begin
         return -pos31(lim);
      end
      return x;
   endfunction

endpackage

// ----- rtl/mcc_mul.sv -----
// Shared Q-format multiplier: exact 32x32 signed product, floor-shifted by FRAC_BITS.
// Depends on mcc_pkg. Result is registered and appears in the cycle after start.
module mcc_mul (
   input  logic                 clock,
   input  mcc_pkg::mul_req_type req,
   output mcc_pkg::wide_type    result
);

   logic signed [2*mcc_pkg::DATA_W-1:0] prod;
   mcc_pkg::wide_type                   result_ff;
   mcc_pkg::wide_type                   result_in;

   assign prod      = req.a * req.b;
   assign result_in = mcc_pkg::WIDE_W'(prod >>> mcc_pkg::FRAC_BITS);

   always_ff @(posedge clock) begin
      if (req.start) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ----- rtl/motor_cascade_controller_top.sv -----
// Motor cascade controller: one control tick per request, one current command per tick.
// The sequencer path from request transfer to response valid depends on mode and run state;
// one tick is in work at a time, as a new request is accepted only in the idle state.
// Every product runs through the single shared 32x32 multiplier.
// Synchronous active-high reset restores the register defaults and zeroes all setpoints.
// Depends on mcc_pkg, mcc_mul and motor_cascade_controller_top_assert.svh.
`include "motor_cascade_controller_top_assert.svh"
module motor_cascade_controller_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mcc_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mcc_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [mcc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mcc_pkg::CFG_W-1:0]           csr_wdata
);

   // configuration registers
   mcc_pkg::mode_type               mode_ff;
   logic [mcc_pkg::CFG_W-1:0]       ramp_ff, ffg_ff, pg_ff, vg_ff, ig_ff, vl_ff, cl_ff;

   // sequencer and loop state
   mcc_pkg::state_type              state_ff, state_in;
   mcc_pkg::req_type                in_ff, in_in;
   logic signed [mcc_pkg::DATA_W-1:0] cs_ff, cs_in, vs_ff, vs_in, ps_ff, ps_in, vi_ff, vi_in;
   logic signed [mcc_pkg::DATA_W-1:0] verr_ff, verr_in;
   mcc_pkg::wide_type               acc_ff, acc_in, vd_ff, vd_in, iq_ff, iq_in;
   logic                            lim_ff, lim_in;
   mcc_pkg::rsp_type                out_ff, out_in;
   logic                            out_valid_ff, out_valid_in;

   mcc_pkg::mul_req_type            mul_req;
   mcc_pkg::wide_type               mul_res;

   // combinational scratch
   mcc_pkg::wide_type               step, perr, vd, iq;
   logic signed [mcc_pkg::DATA_W-1:0] accel, ps_new;

   mcc_mul u_mul (
      .clock  (clock),
      .req    (mul_req),
      .result (mul_res)
   );

   assign req_ready = (state_ff == mcc_pkg::S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // configuration writes; a mode code of three is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= mcc_pkg::MODE_CURRENT;
         ramp_ff <= mcc_pkg::CFG_W'(65);
         ffg_ff  <= '0;
         pg_ff   <= mcc_pkg::CFG_W'(1310720);
         vg_ff   <= mcc_pkg::CFG_W'(32768);
         ig_ff   <= mcc_pkg::CFG_W'(16);
         vl_ff   <= mcc_pkg::CFG_W'(655360);
         cl_ff   <= mcc_pkg::CFG_W'(655360);
      end else if (csr_we) begin
         case (mcc_pkg::csr_idx_type'(csr_index))
            mcc_pkg::CSR_MODE: begin
               if (csr_wdata[1:0] != 2'd3) begin
                  mode_ff <= mcc_pkg::mode_type'(csr_wdata[1:0]);
               end
            end
            mcc_pkg::CSR_RAMP_STEP: ramp_ff <= csr_wdata;
            mcc_pkg::CSR_FF_GAIN:   ffg_ff  <= csr_wdata;
            mcc_pkg::CSR_POS_GAIN:  pg_ff   <= csr_wdata;
            mcc_pkg::CSR_VEL_GAIN:  vg_ff   <= csr_wdata;
            mcc_pkg::CSR_INT_GAIN:  ig_ff   <= csr_wdata;
            mcc_pkg::CSR_VEL_LIMIT: vl_ff   <= csr_wdata;
            mcc_pkg::CSR_CUR_LIMIT: cl_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcc_pkg::S_IDLE;
         cs_ff        <= '0;
         vs_ff        <= '0;
         ps_ff        <= '0;
         vi_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cs_ff        <= cs_in;
         vs_ff        <= vs_in;
         ps_ff        <= ps_in;
         vi_ff        <= vi_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath payload registers
   always_ff @(posedge clock) begin
      in_ff   <= in_in;
      acc_ff  <= acc_in;
      vd_ff   <= vd_in;
      iq_ff   <= iq_in;
      verr_ff <= verr_in;
      lim_ff  <= lim_in;
      out_ff  <= out_in;
   end

   // sequencer: each state issues at most one product to the shared multiplier
   always_comb begin
      state_in     = state_ff;
      in_in        = in_ff;
      cs_in        = cs_ff;
      vs_in        = vs_ff;
      ps_in        = ps_ff;
      vi_in        = vi_ff;
      acc_in       = acc_ff;
      vd_in        = vd_ff;
      iq_in        = iq_ff;
      verr_in      = verr_ff;
      lim_in       = lim_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      mul_req      = '0;
      step         = '0;
      perr         = '0;
      vd           = '0;
      iq           = '0;
      accel        = '0;
      ps_new       = '0;

      case (state_ff)
         mcc_pkg::S_IDLE: begin
            if (req_valid) begin
               in_in    = req_data;
               state_in = mcc_pkg::S_SETPT;
               // restart reloads before the tick runs
               if (req_data.restart) begin
                  cs_in = '0;
                  vs_in = '0;
                  ps_in = req_data.measured_position;
                  vi_in = '0;
               end
            end
         end

         mcc_pkg::S_SETPT: begin
            if (!in_ff.running) begin
               // calibration hold: wrapped angle error into a velocity demand
               perr = mcc_pkg::ext32(in_ff.target) -
                      ((mcc_pkg::pos31(mcc_pkg::CFG_W'(in_ff.angle_in_turn))
                        <<< mcc_pkg::ANGLE_SHL) >>> mcc_pkg::ANGLE_SHR);
               if (perr > mcc_pkg::HALF_TURN) begin
                  perr = perr - mcc_pkg::ONE_TURN;
               end
               if (perr < -mcc_pkg::HALF_TURN) begin
                  perr = perr + mcc_pkg::ONE_TURN;
               end
               mul_req  = '{1'b1, {1'b0, pg_ff}, mcc_pkg::sat32(perr)};
               state_in = mcc_pkg::S_HOLD;
            end else begin
               case (mode_ff)
                  mcc_pkg::MODE_CURRENT: begin
                     step     = mcc_pkg::clamp_sym(mcc_pkg::ext32(in_ff.target) -
                                                   mcc_pkg::ext32(cs_ff), ramp_ff);
                     cs_in    = mcc_pkg::sat32(mcc_pkg::ext32(cs_ff) + step);
                     vd_in    = mcc_pkg::ext32(vs_ff);
                     state_in = mcc_pkg::S_VLIM;
                  end
                  mcc_pkg::MODE_VELOCITY: begin
                     step     = mcc_pkg::clamp_sym(mcc_pkg::ext32(in_ff.target) -
                                                   mcc_pkg::ext32(vs_ff), ramp_ff);
                     accel    = mcc_pkg::sat32(step <<< mcc_pkg::PERIOD_SHIFT);
                     vs_in    = mcc_pkg::sat32(mcc_pkg::ext32(vs_ff) + step);
                     mul_req  = '{1'b1, {1'b0, ffg_ff}, accel};
                     state_in = mcc_pkg::S_FF;
                  end
                  mcc_pkg::MODE_POSITION: begin
                     mul_req  = '{1'b1, mcc_pkg::FILTER_KP,
                                  mcc_pkg::sat32(mcc_pkg::ext32(in_ff.target) -
                                                 mcc_pkg::ext32(ps_ff))};
                     state_in = mcc_pkg::S_F1;
                  end
                  default: begin
                     vd_in    = mcc_pkg::ext32(vs_ff);
                     state_in = mcc_pkg::S_VLIM;
                  end
               endcase
            end
         end

         mcc_pkg::S_HOLD: begin
            vd_in    = mul_res;
            state_in = mcc_pkg::S_VLIM;
         end

         mcc_pkg::S_FF: begin
            cs_in    = mcc_pkg::sat32(mul_res);
            vd_in    = mcc_pkg::ext32(vs_ff);
            state_in = mcc_pkg::S_VLIM;
         end

         // tracking filter: KP*dpos + KI*dvel, then integrate twice
         mcc_pkg::S_F1: begin
            acc_in   = mul_res;
            mul_req  = '{1'b1, mcc_pkg::FILTER_KI, mcc_pkg::sat32(-mcc_pkg::ext32(vs_ff))};
            state_in = mcc_pkg::S_F2;
         end

         mcc_pkg::S_F2: begin
            accel    = mcc_pkg::sat32(acc_ff + mul_res);
            mul_req  = '{1'b1, {1'b0, ffg_ff}, accel};
            vs_in    = mcc_pkg::sat32(mcc_pkg::ext32(vs_ff) +
                                      (mcc_pkg::ext32(accel) >>> mcc_pkg::PERIOD_SHIFT));
            state_in = mcc_pkg::S_F3;
         end

         mcc_pkg::S_F3: begin
            cs_in    = mcc_pkg::sat32(mul_res);
            ps_new   = mcc_pkg::sat32(mcc_pkg::ext32(ps_ff) +
                                      (mcc_pkg::ext32(vs_ff) >>> mcc_pkg::PERIOD_SHIFT));
            ps_in    = ps_new;
            mul_req  = '{1'b1, {1'b0, pg_ff},
                         mcc_pkg::sat32(mcc_pkg::ext32(ps_new) -
                                        mcc_pkg::ext32(in_ff.measured_position))};
            state_in = mcc_pkg::S_F4;
         end

         mcc_pkg::S_F4: begin
            vd_in    = mcc_pkg::ext32(vs_ff) + mul_res;
            state_in = mcc_pkg::S_VLIM;
         end

         mcc_pkg::S_VLIM: begin
            vd = mcc_pkg::clamp_sym(vd_ff, vl_ff);
            if (mode_ff != mcc_pkg::MODE_CURRENT) begin
               verr_in  = mcc_pkg::sat32(vd - mcc_pkg::ext32(in_ff.measured_velocity));
               mul_req  = '{1'b1, {1'b0, vg_ff}, verr_in};
               state_in = mcc_pkg::S_PI;
            end else begin
               verr_in  = '0;
               mul_req  = '{1'b1, mcc_pkg::sat32(mcc_pkg::pos31(vl_ff) -
                                                 mcc_pkg::ext32(in_ff.measured_velocity)),
                            {1'b0, vg_ff}};
               state_in = mcc_pkg::S_IMAX;
            end
         end

         mcc_pkg::S_PI: begin
            iq_in    = mcc_pkg::ext32(cs_ff) + mul_res + mcc_pkg::ext32(vi_ff);
            state_in = mcc_pkg::S_CLIM;
         end

         // current mode: window that keeps velocity inside its limit
         mcc_pkg::S_IMAX: begin
            acc_in   = mul_res;
            mul_req  = '{1'b1, mcc_pkg::sat32(-mcc_pkg::pos31(vl_ff) -
                                              mcc_pkg::ext32(in_ff.measured_velocity)),
                         {1'b0, vg_ff}};
            state_in = mcc_pkg::S_IMIN;
         end

         mcc_pkg::S_IMIN: begin
            iq = mcc_pkg::ext32(cs_ff);
            if (iq > acc_ff) begin
               iq = acc_ff;
            end else if (iq < mul_res) begin
               iq = mul_res;
            end
            iq_in    = iq;
            state_in = mcc_pkg::S_CLIM;
         end

         mcc_pkg::S_CLIM: begin
            iq     = iq_ff;
            lim_in = 1'b0;
            if (iq > mcc_pkg::pos31(cl_ff)) begin
               iq     = mcc_pkg::pos31(cl_ff);
               lim_in = 1'b1;
            end
            if (iq < -mcc_pkg::pos31(cl_ff)) begin
               iq     = -mcc_pkg::pos31(cl_ff);
               lim_in = 1'b1;
            end
            iq_in = iq;
            if (mode_ff == mcc_pkg::MODE_CURRENT) begin
               vi_in    = '0;
               state_in = mcc_pkg::S_DONE;
            end else begin
               // clipped: decay the integrator, else accumulate
               if (lim_in) begin
                  mul_req = '{1'b1, vi_ff, mcc_pkg::DECAY_Q};
               end else begin
                  mul_req = '{1'b1, {1'b0, ig_ff}, verr_ff};
               end
               state_in = mcc_pkg::S_INT;
            end
         end

         mcc_pkg::S_INT: begin
            if (lim_ff) begin
               vi_in = mcc_pkg::sat32(mul_res);
            end else begin
               vi_in = mcc_pkg::sat32(mcc_pkg::ext32(vi_ff) + mul_res);
            end
            state_in = mcc_pkg::S_DONE;
         end

         mcc_pkg::S_DONE: begin
            // hand off once the response register is free
            if (!out_valid_ff || rsp_ready) begin
               out_in.current_command = iq_ff[mcc_pkg::DATA_W-1:0];
               out_in.saturated       = lim_ff;
               out_valid_in           = 1'b1;
               state_in               = mcc_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = mcc_pkg::S_IDLE;
         end
      endcase
   end

   `MCC_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff != mcc_pkg::S_IDLE)
   `MCC_ASSERT_IMPL(a_sat_at_limit, clock, reset, rsp_valid && rsp_data.saturated, (mcc_pkg::ext32(rsp_data.current_command) == mcc_pkg::pos31(cl_ff)) || (mcc_pkg::ext32(rsp_data.current_command) == -mcc_pkg::pos31(cl_ff)))
   `MCC_ASSERT_NEXT(a_int_zero_cur_mode, clock, reset, (state_ff == mcc_pkg::S_CLIM) && (mode_ff == mcc_pkg::MODE_CURRENT), vi_ff == '0)
   `MCC_ASSERT_IMPL(a_mul_busy_only, clock, reset, mul_req.start, state_ff != mcc_pkg::S_IDLE)

endmodule
